/* rtl/range_limited_grid_reach_defines.svh */
// Assertion helpers for the grid reach block.
`ifndef RANGE_LIMITED_GRID_REACH_DEFINES_SVH
`define RANGE_LIMITED_GRID_REACH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLGR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rlgr_pkg.sv */
`default_nettype none
package rlgr_pkg;

	localparam int DEF_MAX_ROWS = 8;
	localparam int DEF_MAX_COLS = 8;
	localparam int OUT_LIMIT    = 64;
	localparam int COST_W       = 6;
	localparam int CFG_W        = 4;

	localparam logic [CFG_W-1:0] GRID_RESET = 4'd8;

	// Operation codes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_MOVE   = 2'd1;
	localparam logic [1:0] OP_ATTACK = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// Register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] pos_x;
		logic [2:0] pos_y;
		logic       occupied;
		logic [1:0] team;
		logic [5:0] reach_range;
	} in_item_t;

	typedef struct packed {
		logic [2:0] cell_x;
		logic [2:0] cell_y;
		logic       found;
		logic       last;
	} out_item_t;

endpackage
`default_nettype wire

/* rtl/range_limited_grid_reach.sv */
// Channel | dir | handshake                  | payload
// in      | in  | in_valid / in_ready        | in_item  (rlgr_pkg::in_item_t)
// out     | out | out_valid / out_ready      | out_item (rlgr_pkg::out_item_t)
// cfg     | in  | cfg_we                     | cfg_index, cfg_data
//
// A write item to a cell in the grid is stored as it is taken. A query dequeues each cell,
// checks its in-grid neighbors against the cell and mark memories (both read through
// registered ports) and skips neighbors off the grid; once it finds the queue empty it scans
// every cell of the full grid, which also clears the mark memory, and presents the final item.
// After reset a sweep over all MAX_ROWS*MAX_COLS cells empties the cell and mark memories;
// no item is taken during it. The scan stalls only when a further cell is found while
// one is pending and the output register holds an item that is not taken.
`default_nettype none
`include "range_limited_grid_reach_defines.svh"
module range_limited_grid_reach #(
	parameter int MAX_ROWS = rlgr_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rlgr_pkg::DEF_MAX_COLS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire rlgr_pkg::in_item_t                in_item,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      rlgr_pkg::out_item_t               out_item,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [rlgr_pkg::CFG_W-1:0]        cfg_data
);
	import rlgr_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int CIW   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int QPW   = $clog2(CELLS + 1);
	localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int QEW   = YW + XW + COST_W;
	localparam logic [CIW-1:0] LAST_CELL = CIW'(CELLS - 1);
	localparam logic [XW-1:0]  LAST_X    = XW'(MAX_COLS - 1);
	localparam logic [YW-1:0]  LAST_Y    = YW'(MAX_ROWS - 1);
	localparam logic [QPW-1:0] CELLS_Q   = QPW'(CELLS);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_POP   = 4'd2;
	localparam logic [3:0] ST_POPW  = 4'd3;
	localparam logic [3:0] ST_NB    = 4'd4;
	localparam logic [3:0] ST_NBW   = 4'd5;
	localparam logic [3:0] ST_SCAN  = 4'd6;
	localparam logic [3:0] ST_SCANW = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	localparam logic [1:0] DIR_XP = 2'd0;
	localparam logic [1:0] DIR_XM = 2'd1;
	localparam logic [1:0] DIR_YP = 2'd2;
	localparam logic [1:0] DIR_YM = 2'd3;

	// Mark entry bits
	localparam int MK_VISIT  = 1;
	localparam int MK_REPORT = 0;
	// Cell entry bit
	localparam int CL_OCC = 2;

	logic [3:0]        state_q;
	logic [CFG_W-1:0]  rows_q, cols_q;
	logic [QPW-1:0]    head_q, tail_q;
	logic [CIW-1:0]    clr_q;
	logic [XW-1:0]     cur_x_q, nb_x_q, sx_q, pend_x_q;
	logic [YW-1:0]     cur_y_q, nb_y_q, sy_q, pend_y_q;
	logic [COST_W-1:0] cost_q, range_q;
	logic [1:0]        dir_q, team_q;
	logic              attack_q;
	logic [CIW-1:0]    nb_idx_q;
	logic [6:0]        cnt_q;
	logic              pend_valid_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	// Memories
	logic [2:0]     cell_mem [CELLS];
	logic [1:0]     mark_mem [CELLS];
	logic [QEW-1:0] queue_mem [CELLS];
	logic [2:0]     cell_rd_q;
	logic [1:0]     mark_rd_q;
	logic [QEW-1:0] queue_rd_q;

	logic           cell_we, mark_we, queue_we;
	logic [CIW-1:0] cell_wa, cell_ra, mark_wa, mark_ra, queue_wa, queue_ra;
	logic [2:0]     cell_wd;
	logic [1:0]     mark_wd;
	logic [QEW-1:0] queue_wd;

	logic              in_fire, slot_free, start_ok, is_query, out_load;
	logic [XW-1:0]     start_x, nb_x;
	logic [YW-1:0]     start_y, nb_y;
	logic [CIW-1:0]    start_idx, nb_idx, scan_idx;
	logic              nb_ok, nb_enqueue, scan_hit;
	logic [XW-1:0]     q_x;
	logic [YW-1:0]     q_y;
	logic [COST_W-1:0] q_cost;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign slot_free = !out_valid_q || out_ready;

	// Decode the start cell and check it against the grid in use
	assign start_x   = XW'(in_item.pos_x);
	assign start_y   = YW'(in_item.pos_y);
	assign start_ok  = (int'(in_item.pos_x) < int'(cols_q)) && (int'(in_item.pos_x) < MAX_COLS)
		&& (int'(in_item.pos_y) < int'(rows_q)) && (int'(in_item.pos_y) < MAX_ROWS);
	assign start_idx = CIW'(int'(start_y) * MAX_COLS + int'(start_x));
	assign is_query  = (in_item.operation == OP_MOVE) || (in_item.operation == OP_ATTACK);

	assign {q_y, q_x, q_cost} = queue_rd_q;
	assign scan_idx = CIW'(int'(sy_q) * MAX_COLS + int'(sx_q));
	assign scan_hit = mark_rd_q[MK_REPORT] && (cnt_q < 7'(OUT_LIMIT));

	// Load the output register with a pushed-out cell or the final item
	assign out_load = slot_free && ((state_q == ST_DONE)
		|| ((state_q == ST_SCANW) && scan_hit && pend_valid_q));

	// Pick the neighbor in the current direction
	always_comb begin
		nb_x  = cur_x_q;
		nb_y  = cur_y_q;
		nb_ok = 1'b0;
		unique case (dir_q)
			DIR_XP: begin
				nb_x  = cur_x_q + XW'(1);
				nb_ok = (int'(cur_x_q) + 1 < int'(cols_q)) && (int'(cur_x_q) + 1 < MAX_COLS);
			end
			DIR_XM: begin
				nb_x  = cur_x_q - XW'(1);
				nb_ok = (cur_x_q != '0);
			end
			DIR_YP: begin
				nb_y  = cur_y_q + YW'(1);
				nb_ok = (int'(cur_y_q) + 1 < int'(rows_q)) && (int'(cur_y_q) + 1 < MAX_ROWS);
			end
			DIR_YM: begin
				nb_y  = cur_y_q - YW'(1);
				nb_ok = (cur_y_q != '0);
			end
			default: ;
		endcase
	end
	assign nb_idx = CIW'(int'(nb_y) * MAX_COLS + int'(nb_x));

	// Neighbor is empty and not yet seen: extend the walk through it
	assign nb_enqueue = (state_q == ST_NBW) && !mark_rd_q[MK_VISIT] && !cell_rd_q[CL_OCC]
		&& (tail_q < CELLS_Q);

	// Drive memory ports
	always_comb begin
		cell_we  = 1'b0;
		cell_wa  = start_idx;
		cell_wd  = in_item.occupied ? {1'b1, in_item.team} : 3'b000;
		cell_ra  = nb_idx;
		mark_we  = 1'b0;
		mark_wa  = nb_idx_q;
		mark_wd  = 2'b00;
		mark_ra  = (state_q == ST_SCAN) ? scan_idx : nb_idx;
		queue_we = 1'b0;
		queue_wa = tail_q[CIW-1:0];
		queue_wd = {nb_y_q, nb_x_q, cost_q + COST_W'(1)};
		queue_ra = head_q[CIW-1:0];
		unique case (state_q)
			ST_CLR: begin
				cell_we = 1'b1;
				cell_wa = clr_q;
				cell_wd = 3'b000;
				mark_we = 1'b1;
				mark_wa = clr_q;
			end
			ST_IDLE: begin
				if (in_fire && start_ok) begin
					if (in_item.operation == OP_WRITE) begin
						cell_we = 1'b1;
					end else if (is_query) begin
						mark_we  = 1'b1;
						mark_wa  = start_idx;
						mark_wd  = 2'b10;
						queue_we = 1'b1;
						queue_wa = '0;
						queue_wd = {start_y, start_x, COST_W'(0)};
					end
				end
			end
			ST_NBW: begin
				if (!mark_rd_q[MK_VISIT]) begin
					if (cell_rd_q[CL_OCC]) begin
						mark_we = attack_q;
						mark_wd = {1'b1, cell_rd_q[1:0] != team_q};
					end else begin
						mark_we  = 1'b1;
						mark_wd  = {1'b1, !attack_q};
						queue_we = nb_enqueue;
					end
				end
			end
			ST_SCAN: begin
				// read and clear in the same cycle
				mark_we = 1'b1;
				mark_wa = scan_idx;
			end
			default: ;
		endcase
	end

	// Cell store
	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd_q <= cell_mem[cell_ra];
	end

	// Visit and report marks; hold the scanned mark while the scan waits
	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (state_q != ST_SCANW) mark_rd_q <= mark_mem[mark_ra];
	end

	// Walk queue
	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[queue_wa] <= queue_wd;
		queue_rd_q <= queue_mem[queue_ra];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			rows_q       <= GRID_RESET;
			cols_q       <= GRID_RESET;
			head_q       <= '0;
			tail_q       <= '0;
			clr_q        <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			nb_x_q       <= '0;
			nb_y_q       <= '0;
			nb_idx_q     <= '0;
			cost_q       <= '0;
			range_q      <= '0;
			dir_q        <= DIR_XP;
			team_q       <= '0;
			attack_q     <= 1'b0;
			sx_q         <= '0;
			sy_q         <= '0;
			pend_x_q     <= '0;
			pend_y_q     <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
		end else begin
			// Take configuration writes at any time
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_q <= cfg_data;
					REG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end

			// Present a new output item, or drop the current one once taken
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CIW'(1);
					if (clr_q == LAST_CELL) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire && is_query) begin
						attack_q     <= (in_item.operation == OP_ATTACK);
						team_q       <= in_item.team;
						range_q      <= in_item.reach_range;
						sx_q         <= '0;
						sy_q         <= '0;
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
						head_q       <= '0;
						tail_q       <= QPW'(1);
						state_q      <= start_ok ? ST_POP : ST_SCAN;
					end
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						state_q <= ST_SCAN;
					end else begin
						head_q  <= head_q + QPW'(1);
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					cur_x_q <= q_x;
					cur_y_q <= q_y;
					cost_q  <= q_cost;
					dir_q   <= DIR_XP;
					if ({1'b0, q_cost} + 7'd1 > {1'b0, range_q}) state_q <= ST_POP;
					else state_q <= ST_NB;
				end
				ST_NB: begin
					if (nb_ok) begin
						nb_x_q   <= nb_x;
						nb_y_q   <= nb_y;
						nb_idx_q <= nb_idx;
						state_q  <= ST_NBW;
					end else if (dir_q == DIR_YM) begin
						state_q <= ST_POP;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				ST_NBW: begin
					if (nb_enqueue) tail_q <= tail_q + QPW'(1);
					if (dir_q == DIR_YM) begin
						state_q <= ST_POP;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= ST_NB;
					end
				end
				ST_SCAN: begin
					state_q <= ST_SCANW;
				end
				ST_SCANW: begin
					// Hold while a found cell cannot push the pending one out
					if (!(scan_hit && pend_valid_q && !slot_free)) begin
						if (scan_hit) begin
							if (pend_valid_q) begin
								out_item_q.cell_x <= 3'(pend_x_q);
								out_item_q.cell_y <= 3'(pend_y_q);
								out_item_q.found  <= 1'b1;
								out_item_q.last   <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_x_q     <= sx_q;
							pend_y_q     <= sy_q;
							cnt_q        <= cnt_q + 7'd1;
						end
						// Advance in row-major order
						if (sx_q == LAST_X) begin
							sx_q <= '0;
							if (sy_q == LAST_Y) begin
								state_q <= ST_DONE;
							end else begin
								sy_q    <= sy_q + YW'(1);
								state_q <= ST_SCAN;
							end
						end else begin
							sx_q    <= sx_q + XW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DONE: begin
					// Flush the last item or the empty answer
					if (slot_free) begin
						out_item_q.cell_x <= pend_valid_q ? 3'(pend_x_q) : 3'd0;
						out_item_q.cell_y <= pend_valid_q ? 3'(pend_y_q) : 3'd0;
						out_item_q.found  <= pend_valid_q;
						out_item_q.last   <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RLGR_ASSERT_NOW(a_tail_bound, 1'b1, tail_q <= CELLS_Q, "walk queue overran")
	`RLGR_ASSERT_NOW(a_head_le_tail, 1'b1, head_q <= tail_q, "queue head passed tail")
	`RLGR_ASSERT_NOW(a_empty_is_last, out_valid_q && !out_item_q.found, out_item_q.last,
		"empty answer without last")
	`RLGR_ASSERT_NEXT(a_done_emits, state_q == ST_DONE && slot_free,
		out_valid_q && out_item_q.last, "final item not presented")

endmodule
`default_nettype wire

/* dv/range_limited_grid_reach_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module range_limited_grid_reach_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire rlgr_pkg::in_item_t   in_item,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire rlgr_pkg::out_item_t  out_item,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [3:0]           cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        cells_reported,
	output int                        queries_seen
);
	import rlgr_pkg::*;

	logic [2:0] board [64];
	logic [3:0] rows_reg, cols_reg;
	out_item_t  cell_list [$];

	function automatic int clip8(logic [3:0] v);
		return (v > 4'd8) ? 8 : int'(v);
	endfunction

	// Walk the grid from the start cell and queue the reported cells in ascending order
	task automatic predict_reach(in_item_t it);
		int rows, cols, head, tail, cur, cx, cy, nx, ny, ni, d;
		int ring_cell [64];
		int ring_cost [64];
		bit seen [64];
		bit hit [64];
		int dx [4];
		int dy [4];
		int n;
		out_item_t r;
		dx = '{1, -1, 0, 0};
		dy = '{0, 0, 1, -1};
		rows = clip8(rows_reg);
		cols = clip8(cols_reg);
		n = 0;
		foreach (seen[i]) begin
			seen[i] = 0;
			hit[i] = 0;
		end
		if (it.pos_x < cols && it.pos_y < rows) begin
			head = 0;
			tail = 1;
			ring_cell[0] = it.pos_y * 8 + it.pos_x;
			ring_cost[0] = 0;
			seen[ring_cell[0]] = 1;
			while (head < tail) begin
				cur = ring_cell[head];
				cx = cur % 8;
				cy = cur / 8;
				head++;
				if (ring_cost[head-1] + 1 > it.reach_range) continue;
				for (d = 0; d < 4; d++) begin
					nx = cx + dx[d];
					ny = cy + dy[d];
					if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
					ni = ny * 8 + nx;
					if (seen[ni]) continue;
					if (board[ni][2]) begin
						if (it.operation == OP_ATTACK) begin
							seen[ni] = 1;
							if (board[ni][1:0] != it.team) hit[ni] = 1;
						end
						continue;
					end
					seen[ni] = 1;
					if (it.operation == OP_MOVE) hit[ni] = 1;
					if (tail < 64) begin
						ring_cell[tail] = ni;
						ring_cost[tail] = ring_cost[head-1] + 1;
						tail++;
					end
				end
			end
		end
		for (int i = 0; i < 64; i++) begin
			if (hit[i]) begin
				r.cell_x = 3'(i % 8);
				r.cell_y = 3'(i / 8);
				r.found = 1'b1;
				r.last = 1'b0;
				cell_list.push_back(r);
				n++;
			end
		end
		if (n == 0) begin
			r = '0;
			cell_list.push_back(r);
		end
		r = cell_list.pop_back();
		r.last = 1'b1;
		cell_list.push_back(r);
	endtask

	// Track config and board, predict queries, compare results
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (board[i]) board[i] = '0;
			rows_reg = GRID_RESET;
			cols_reg = GRID_RESET;
			fail_count = 0;
			pending = 0;
			cells_reported = 0;
			queries_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROWS) rows_reg = cfg_data;
				else cols_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (in_item.operation == OP_WRITE) begin
					if (in_item.pos_x < clip8(cols_reg) && in_item.pos_y < clip8(rows_reg))
						board[in_item.pos_y * 8 + in_item.pos_x] =
							in_item.occupied ? {1'b1, in_item.team} : 3'b000;
				end else if (in_item.operation != OP_NONE) begin
					predict_reach(in_item);
					queries_seen++;
				end
			end
			if (out_valid && out_ready) begin
				if (out_item.found) cells_reported++;
				if (cell_list.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected item: %p", out_item);
				end else begin
					want = cell_list.pop_front();
					if (want !== out_item) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p got %p", want, out_item);
					end
				end
			end
			pending = cell_list.size();
		end
	end
endmodule
`default_nettype wire

/* dv/range_limited_grid_reach_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module range_limited_grid_reach_tb;
	import rlgr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	in_item_t in_item = '0;
	out_item_t out_item;
	logic cfg_we = 0, cfg_index = 0;
	logic [3:0] cfg_data = '0;
	int fail_count, pending, cells_reported, queries_seen;
	int cycles = 0;
	bit hold_off = 0;

	range_limited_grid_reach u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	range_limited_grid_reach_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.cells_reported(cells_reported), .queries_seen(queries_seen)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, with one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 0;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_item(in_item_t it);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_grid(logic [3:0] rows, logic [3:0] cols);
		drain();
		cfg_we <= 1;
		cfg_index <= REG_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		cfg_index <= REG_COLS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic in_item_t make_item(logic [1:0] op, int x, int y, bit occ,
			int team, int rng);
		in_item_t it;
		it.operation = op;
		it.pos_x = 3'(x);
		it.pos_y = 3'(y);
		it.occupied = occ;
		it.team = 2'(team);
		it.reach_range = 6'(rng);
		return it;
	endfunction

	// Random item: mostly board writes and queries, a little unused-op noise
	function automatic in_item_t rand_item();
		int r;
		logic [1:0] op;
		in_item_t it;
		r = $urandom_range(0, 99);
		op = (r < 45) ? OP_WRITE : (r < 70) ? OP_MOVE : (r < 97) ? OP_ATTACK : OP_NONE;
		it = in_item_t'($urandom);
		it.operation = op;
		if (op == OP_WRITE) it.occupied = ($urandom_range(0, 2) == 0);
		if (op != OP_WRITE && $urandom_range(0, 2) != 0)
			it.reach_range = 6'($urandom_range(0, 8));
		return it;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: corners, blocking walls, enemies, ranges
		send_item(make_item(OP_MOVE, 0, 0, 0, 0, 0));
		send_item(make_item(OP_MOVE, 7, 7, 0, 3, 63));
		send_item(make_item(OP_WRITE, 1, 0, 1, 1, 0));
		send_item(make_item(OP_WRITE, 0, 1, 1, 2, 0));
		send_item(make_item(OP_WRITE, 0, 0, 1, 3, 0));
		send_item(make_item(OP_ATTACK, 0, 0, 0, 1, 5));
		send_item(make_item(OP_MOVE, 0, 0, 0, 1, 5));
		send_item(make_item(OP_WRITE, 1, 0, 0, 0, 0));
		send_item(make_item(OP_MOVE, 0, 0, 0, 0, 2));
		send_item(make_item(OP_ATTACK, 3, 3, 0, 2, 63));
		send_item(make_item(OP_NONE, 5, 5, 1, 3, 63));
		send_item(make_item(OP_WRITE, 7, 7, 1, 3, 63));
		send_item(make_item(OP_ATTACK, 7, 6, 0, 3, 1));
		send_item(make_item(OP_ATTACK, 7, 6, 0, 0, 1));
		send_item(make_item(OP_MOVE, 4, 4, 1, 2, 1));

		// Small grid with writes outside it, then zero and oversized grids
		set_grid(4'd3, 4'd2);
		send_item(make_item(OP_WRITE, 5, 5, 1, 1, 0));
		send_item(make_item(OP_MOVE, 2, 0, 0, 0, 9));
		send_item(make_item(OP_MOVE, 1, 2, 0, 0, 9));
		set_grid(4'd0, 4'd8);
		send_item(make_item(OP_MOVE, 0, 0, 0, 0, 9));
		set_grid(4'd15, 4'd1);
		send_item(make_item(OP_MOVE, 0, 3, 0, 0, 63));
		set_grid(4'd1, 4'd15);
		send_item(make_item(OP_ATTACK, 3, 0, 0, 1, 63));
		set_grid(4'd8, 4'd8);
		send_item(make_item(OP_ATTACK, 6, 6, 0, 0, 63));

		// Long receiver hold-off while queries keep coming
		hold_off = 1;
		repeat (6) send_item(make_item(OP_MOVE, $urandom_range(0, 7),
			$urandom_range(0, 7), 0, $urandom_range(0, 3), 63));

		// Random phases over several grid sizes
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) set_grid(4'd1, 4'd1);
			else if (ph > 0)
				set_grid(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			repeat (45) send_item(rand_item());
		end
		set_grid(4'd8, 4'd8);
		repeat (20) send_item(rand_item());

		drain();
		$display("queries checked: %0d, cells reported: %0d", queries_seen, cells_reported);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
